FILE: rtl/core/nfcrq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nfcrq_pkg
// shared types and constants of the nec frame check and repeat queue
// ----------------------------------------------------------------------------
package nfcrq_pkg;

  localparam logic       OP_FRAME = 1'b0;
  localparam logic       OP_READ  = 1'b1;

  localparam logic [2:0] ST_QUEUED    = 3'd0;
  localparam logic [2:0] ST_DROPPED   = 3'd1;
  localparam logic [2:0] ST_MALFORMED = 3'd2;
  localparam logic [2:0] ST_READ_OK   = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;

  localparam logic [15:0] REPEAT_WINDOW_RESET = 16'd130;
  localparam logic [7:0]  BYTE_ONES           = 8'hff;

  typedef struct packed {
    logic [15:0] address;
    logic [7:0]  command;
  } key_t;

  typedef struct packed {
    logic ok;
    key_t key;
  } chk_result_t;

  typedef struct packed {
    logic        repeat_flag;
    logic [15:0] address;
    logic [7:0]  command;
  } ring_entry_t;

endpackage : nfcrq_pkg
`default_nettype wire

FILE: rtl/core/nfcrq_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nfcrq channel interfaces
// valid/ready channels for requests and results
// ----------------------------------------------------------------------------
interface nfcrq_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] raw_frame;
  logic [31:0] now_ms;

  modport source (output valid, op, raw_frame, now_ms, input ready);
  modport sink   (input valid, op, raw_frame, now_ms, output ready);
endinterface : nfcrq_in_if

interface nfcrq_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] event_address;
  logic [7:0]  event_command;
  logic        event_repeat;
  logic [3:0]  pending_count;

  modport source (output valid, status, event_address, event_command, event_repeat,
                  pending_count, input ready);
  modport sink   (input valid, status, event_address, event_command, event_repeat,
                  pending_count, output ready);
endinterface : nfcrq_out_if
`default_nettype wire

FILE: rtl/core/nec_frame_check_repeat_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nec_frame_check_repeat_queue
// nec frame checker with auto-repeat flagging and a dropping event queue
// ----------------------------------------------------------------------------
// usage
//   in_chan carries one transaction per request: op 0 hands over a captured
//   32-bit frame with its millisecond timestamp, op 1 pops one queued event.
//   out_chan returns exactly one result transaction per request.
//   cfg_we/cfg_wdata load the repeat window; the user must do so only while
//   the block is idle, as the block itself does not enforce it.
// timing
//   a frame or a read of an empty queue shows its result in the cycle after
//   it is taken; while out_chan is not stalled requests follow at once (one per
//   cycle). a read of a non-empty queue goes through the ring's registered read
//   port, then the pop state, into the output register; in_chan is held off in it.
// reset
//   rst_n is synchronous, active low; queue pointers, repeat history and the
//   window register (130 ms) are restored, ring contents are left as they are
//   and no clearing pass is needed since only written entries are ever read.
// stall
//   results sit in an output register; while out_chan is stalled a new
//   request is taken only in the cycle the pending result leaves.
// ----------------------------------------------------------------------------
module nec_frame_check_repeat_queue #(
  parameter int RING_DEPTH = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  nfcrq_in_if.sink    in_chan,
  nfcrq_out_if.source out_chan,
  input  wire         cfg_we,
  input  wire  [15:0] cfg_wdata
);
  import nfcrq_pkg::*;

  localparam int PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CW = (PW > 4) ? PW : 4;

  // idle takes requests, pop waits for the ring read data
  localparam logic FSM_IDLE = 1'b0;
  localparam logic FSM_POP  = 1'b1;

  logic          state_r, state_nxt;
  logic [15:0]   window_r;
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  key_t          prev_key_r;
  logic [31:0]   prev_time_r;
  logic          prev_valid_r;

  logic          out_valid_r;
  logic [2:0]    out_status_r;
  ring_entry_t   out_event_r;
  logic [3:0]    out_pending_r;

  chk_result_t   chk;
  logic          accept;
  logic          acc_frame_ok;
  logic          acc_pop;
  logic          queue_empty;
  logic [31:0]   gap;
  logic          is_repeat;
  ring_entry_t   new_event;
  logic [PW-1:0] wr_adv;
  logic          full_hit;
  logic [PW:0]   count_wide;
  logic [CW-1:0] count_ext;
  ring_entry_t   mem_rdata;

  function automatic logic [PW-1:0] slot_next(input logic [PW-1:0] s);
    return (s == PW'(RING_DEPTH - 1)) ? '0 : s + PW'(1);
  endfunction

  nfcrq_frame_chk u_chk (
    .raw_frame (in_chan.raw_frame),
    .result    (chk)
  );

  // handshake
  assign in_chan.ready = (state_r == FSM_IDLE) && (!out_valid_r || out_chan.ready);
  assign accept        = in_chan.valid && in_chan.ready;
  assign queue_empty   = (wr_ptr_r == rd_ptr_r);
  assign acc_frame_ok  = accept && (in_chan.op == OP_FRAME) && chk.ok;
  assign acc_pop       = accept && (in_chan.op == OP_READ) && !queue_empty;

  // repeat detection, the gap wraps modulo 2^32
  assign gap       = in_chan.now_ms - prev_time_r;
  assign is_repeat = prev_valid_r && (prev_key_r == chk.key) && (gap <= {16'h0000, window_r});

  assign new_event.repeat_flag = is_repeat;
  assign new_event.address     = chk.key.address;
  assign new_event.command     = chk.key.command;

  assign wr_adv   = slot_next(wr_ptr_r);
  assign full_hit = (wr_adv == rd_ptr_r);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (acc_frame_ok) begin
      wr_ptr_nxt = wr_adv;
      // full ring: oldest event goes
      if (full_hit) begin
        rd_ptr_nxt = slot_next(rd_ptr_r);
      end
    end else if (acc_pop) begin
      rd_ptr_nxt = slot_next(rd_ptr_r);
    end
  end

  // occupancy after this request
  always_comb begin
    if (wr_ptr_nxt >= rd_ptr_nxt) begin
      count_wide = {1'b0, wr_ptr_nxt} - {1'b0, rd_ptr_nxt};
    end else begin
      count_wide = {1'b0, wr_ptr_nxt} + (PW+1)'(RING_DEPTH) - {1'b0, rd_ptr_nxt};
    end
    count_ext = CW'(count_wide);
  end

  nfcrq_ring_mem #(
    .DEPTH (RING_DEPTH),
    .AW    (PW)
  ) u_ring (
    .clk   (clk),
    .we    (acc_frame_ok),
    .waddr (wr_ptr_r),
    .wdata (new_event),
    .re    (acc_pop),
    .raddr (rd_ptr_r),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FSM_IDLE: begin
        if (acc_pop) begin
          state_nxt = FSM_POP;
        end
      end
      FSM_POP: begin
        state_nxt = FSM_IDLE;
      end
      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= FSM_IDLE;
      window_r     <= REPEAT_WINDOW_RESET;
      wr_ptr_r     <= '0;
      rd_ptr_r     <= '0;
      prev_key_r   <= '0;
      prev_time_r  <= '0;
      prev_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      if (cfg_we) begin
        window_r <= cfg_wdata;
      end
      if (acc_frame_ok) begin
        prev_key_r   <= chk.key;
        prev_time_r  <= in_chan.now_ms;
        prev_valid_r <= 1'b1;
      end
      if (state_r == FSM_POP) begin
        out_valid_r <= 1'b1;
      end else if (accept) begin
        // a pop shows its result only after the pop state
        out_valid_r <= !acc_pop;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_pending_r <= count_ext[3:0];
      out_event_r   <= '0;
      if (in_chan.op == OP_READ) begin
        out_status_r <= queue_empty ? ST_EMPTY : ST_READ_OK;
      end else if (!chk.ok) begin
        out_status_r <= ST_MALFORMED;
      end else begin
        out_status_r <= full_hit ? ST_DROPPED : ST_QUEUED;
        out_event_r  <= new_event;
      end
    end else if (state_r == FSM_POP) begin
      out_event_r <= mem_rdata;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.status        = out_status_r;
  assign out_chan.event_address = out_event_r.address;
  assign out_chan.event_command = out_event_r.command;
  assign out_chan.event_repeat  = out_event_r.repeat_flag;
  assign out_chan.pending_count = out_pending_r;

  // a queued frame always leaves the ring non-empty
  a_frame_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    acc_frame_ok |=> (wr_ptr_r != rd_ptr_r))
    else $error("ring empty right after a frame was queued");

  // a pop of a non-empty ring delivers its result after the pop state
  a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
    acc_pop |=> ##1 (out_valid_r && (out_status_r == ST_READ_OK)))
    else $error("pop result missing");

  // while waiting on ring data the output register is free
  a_pop_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FSM_POP) |-> (!out_valid_r && !in_chan.ready))
    else $error("output register busy during pop");

endmodule : nec_frame_check_repeat_queue
`default_nettype wire

FILE: rtl/core/nfcrq_ring_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nfcrq_ring_mem
// event ring storage, one write and one registered read port
// ----------------------------------------------------------------------------
module nfcrq_ring_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [AW-1:0]            waddr,
  input  wire  nfcrq_pkg::ring_entry_t wdata,
  input  wire                      re,
  input  wire  [AW-1:0]            raddr,
  output nfcrq_pkg::ring_entry_t   rdata
);
  import nfcrq_pkg::*;

  ring_entry_t mem [DEPTH];
  ring_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule : nfcrq_ring_mem
`default_nettype wire

FILE: rtl/core/nfcrq_frame_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nfcrq_frame_chk
// checks a raw frame as received, then byte-reversed, and extracts the key
// ----------------------------------------------------------------------------
module nfcrq_frame_chk (
  input  wire  [31:0]               raw_frame,
  output nfcrq_pkg::chk_result_t    result
);
  import nfcrq_pkg::*;

  logic [31:0] swapped;
  logic        ok_straight;
  logic        ok_swapped;
  logic [31:0] chosen;
  logic [7:0]  a;
  logic [7:0]  na;

  assign swapped     = {raw_frame[7:0], raw_frame[15:8], raw_frame[23:16], raw_frame[31:24]};
  assign ok_straight = (raw_frame[23:16] ^ raw_frame[31:24]) == BYTE_ONES;
  assign ok_swapped  = (swapped[23:16] ^ swapped[31:24]) == BYTE_ONES;
  assign chosen      = ok_straight ? raw_frame : swapped;
  assign a           = chosen[7:0];
  assign na          = chosen[15:8];

  always_comb begin
    result.ok          = ok_straight | ok_swapped;
    result.key.command = chosen[23:16];
    // complement mismatch means extended addressing, complement byte on top
    result.key.address = ((a ^ na) == BYTE_ONES) ? {8'h00, a} : {na, a};
  end

endmodule : nfcrq_frame_chk
`default_nettype wire
